>>> sv/oss_pkg.sv
// Shared types, codes and field widths of the ordered sequence store.
package oss_pkg;

    // Beat field widths
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CMD_W = 3;
    localparam int IDX_W = 8;
    localparam int CNT_W = 7;
    localparam int IN_W  = 48;
    localparam int OUT_W = 56;

    typedef logic [CMD_W-1:0] op_t;

    localparam op_t OP_INSERT_AT     = 3'd0;
    localparam op_t OP_SORTED_INSERT = 3'd1;
    localparam op_t OP_ERASE_AT      = 3'd2;
    localparam op_t OP_REMOVE_ALL    = 3'd3;
    localparam op_t OP_GET           = 3'd4;
    localparam op_t OP_SET           = 3'd5;
    localparam op_t OP_FIND          = 3'd6;

    // Memory sweep kinds
    typedef enum logic [2:0] {
        SW_NONE = 3'd0,
        SW_SCAN = 3'd1,
        SW_UP   = 3'd2,
        SW_DN   = 3'd3,
        SW_CMP  = 3'd4
    } sweep_t;

    typedef enum logic [1:0] {
        TGT_HOLD = 2'd0,
        TGT_POS  = 2'd1,
        TGT_SCAN = 2'd2
    } tgt_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD    = 2'd0,
        CNT_INC     = 2'd1,
        CNT_DEC     = 2'd2,
        CNT_LOAD_WA = 2'd3
    } cnt_op_t;

    typedef enum logic [1:0] {
        RK_REJECT = 2'd0,
        RK_INDEX  = 2'd1,
        RK_READ   = 2'd2,
        RK_REMOVE = 2'd3
    } res_kind_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      cap;
        sweep_t    init_mode;
        sweep_t    run_mode;
        tgt_sel_t  tgt_sel;
        logic      rd_tgt;
        logic      wr_val;
        cnt_op_t   cnt_op;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic ins_ok;
        logic acc_ok;
        logic full;
        logic hit;
        logic done;
        logic out_free;
    } stat_t;

endpackage

>>> sv/oss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/oss_ctrl.sv
// Command sequencer of the ordered sequence store.
module oss_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  oss_pkg::stat_t stat,
    output oss_pkg::ctl_t  ctl
);
    import oss_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_SCAN   = 9'b000000100,
        S_UP     = 9'b000001000,
        S_DN     = 9'b000010000,
        S_CMP    = 9'b000100000,
        S_READ   = 9'b001000000,
        S_PLACE  = 9'b010000000,
        S_REPLY  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.init_mode = SW_NONE;
        ctl.run_mode  = SW_NONE;
        ctl.tgt_sel   = TGT_HOLD;
        ctl.cnt_op    = CNT_HOLD;
        ctl.res_kind  = RK_REJECT;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.cap    = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                // default: reject with no change
                ctl.res_load = 1'b1;
                ctl.res_kind = RK_REJECT;
                state_next   = S_REPLY;
                case (stat.op)
                    OP_INSERT_AT: begin
                        if (stat.ins_ok && !stat.full) begin
                            ctl.res_load  = 1'b0;
                            ctl.tgt_sel   = TGT_POS;
                            ctl.init_mode = SW_UP;
                            state_next    = S_UP;
                        end
                    end
                    OP_SORTED_INSERT: begin
                        if (!stat.full) begin
                            ctl.res_load  = 1'b0;
                            ctl.init_mode = SW_SCAN;
                            state_next    = S_SCAN;
                        end
                    end
                    OP_ERASE_AT: begin
                        if (stat.acc_ok) begin
                            ctl.res_load  = 1'b0;
                            ctl.tgt_sel   = TGT_POS;
                            ctl.init_mode = SW_DN;
                            state_next    = S_DN;
                        end
                    end
                    OP_REMOVE_ALL: begin
                        ctl.res_load  = 1'b0;
                        ctl.init_mode = SW_CMP;
                        state_next    = S_CMP;
                    end
                    OP_GET: begin
                        if (stat.acc_ok) begin
                            ctl.res_load = 1'b0;
                            ctl.tgt_sel  = TGT_POS;
                            ctl.rd_tgt   = 1'b1;
                            state_next   = S_READ;
                        end
                    end
                    OP_SET: begin
                        if (stat.acc_ok) begin
                            ctl.tgt_sel  = TGT_POS;
                            ctl.wr_val   = 1'b1;
                            ctl.res_kind = RK_INDEX;
                        end
                    end
                    OP_FIND: begin
                        ctl.res_load  = 1'b0;
                        ctl.init_mode = SW_SCAN;
                        state_next    = S_SCAN;
                    end
                    default: begin
                        ctl.res_kind = RK_REJECT;
                    end
                endcase
            end
            S_SCAN: begin
                ctl.run_mode = SW_SCAN;
                if (stat.hit || stat.done) begin
                    if (stat.op == OP_SORTED_INSERT) begin
                        ctl.tgt_sel   = TGT_SCAN;
                        ctl.init_mode = SW_UP;
                        state_next    = S_UP;
                    end else begin
                        ctl.res_load = 1'b1;
                        ctl.tgt_sel  = TGT_SCAN;
                        ctl.res_kind = stat.hit ? RK_INDEX : RK_REJECT;
                        state_next   = S_REPLY;
                    end
                end
            end
            S_UP: begin
                ctl.run_mode = SW_UP;
                if (stat.done) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                ctl.wr_val   = 1'b1;
                ctl.cnt_op   = CNT_INC;
                ctl.res_load = 1'b1;
                ctl.res_kind = RK_INDEX;
                state_next   = S_REPLY;
            end
            S_DN: begin
                ctl.run_mode = SW_DN;
                if (stat.done) begin
                    ctl.cnt_op   = CNT_DEC;
                    ctl.res_load = 1'b1;
                    ctl.res_kind = RK_INDEX;
                    state_next   = S_REPLY;
                end
            end
            S_CMP: begin
                ctl.run_mode = SW_CMP;
                if (stat.done) begin
                    ctl.cnt_op   = CNT_LOAD_WA;
                    ctl.res_load = 1'b1;
                    ctl.res_kind = RK_REMOVE;
                    state_next   = S_REPLY;
                end
            end
            S_READ: begin
                ctl.res_load = 1'b1;
                ctl.res_kind = RK_READ;
                state_next   = S_REPLY;
            end
            S_REPLY: begin
                if (stat.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

>>> sv/oss_dpath.sv
// Datapath of the ordered sequence store: element memory, sweep counters, result registers.
module oss_dpath #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  oss_pkg::ctl_t              ctl,
    output oss_pkg::stat_t             stat,
    input  logic [oss_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [oss_pkg::OUT_W-1:0]  m_tdata
);
    import oss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    op_t              op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [DW-1:0]    val_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    tgt_reg, tgt_next;
    logic [CW-1:0]    ra_reg, ra_next;
    logic [CW-1:0]    wa_reg, wa_next;
    logic             sv_reg, sv_next;
    logic [CW-1:0]    sa_reg, sa_next;

    logic             res_status_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic [VAL_W-1:0] res_rd_reg;
    logic [CNT_W-1:0] res_rem_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic [XW-1:0]    pos_x, cnt_x;
    logic [CW-1:0]    pos_c;
    logic [DW-1:0]    rdata;
    logic             ge, eq, hit, issue, done;
    logic [CW-1:0]    rd_addr, ra_step;
    logic             we;
    logic [CW-1:0]    waddr;
    logic [DW-1:0]    wdata;

    assign pos_x = XW'(pos_reg);
    assign cnt_x = XW'(count_reg);
    assign pos_c = CW'(pos_reg);
    assign ge    = (rdata >= val_reg);
    assign eq    = (rdata == val_reg);
    assign hit   = sv_reg && ((op_reg == OP_SORTED_INSERT) ? ge : eq);

    // Sweep read issue
    always_comb begin
        issue   = 1'b0;
        rd_addr = ra_reg;
        sa_next = ra_reg;
        ra_step = ra_reg;
        unique case (ctl.run_mode)
            SW_UP: begin
                issue   = (ra_reg > tgt_reg);
                rd_addr = ra_reg - CW'(1);
                ra_step = ra_reg - CW'(1);
            end
            SW_DN: begin
                issue   = (ra_reg < count_reg);
                sa_next = ra_reg - CW'(1);
                ra_step = ra_reg + CW'(1);
            end
            SW_SCAN, SW_CMP: begin
                issue   = (ra_reg < count_reg);
                ra_step = ra_reg + CW'(1);
            end
            default: begin
                issue = 1'b0;
            end
        endcase
        if (ctl.rd_tgt) begin
            rd_addr = pos_c;
        end
    end

    assign done    = !issue && !sv_reg;
    assign sv_next = issue && !((ctl.run_mode == SW_SCAN) && hit);

    always_comb begin
        case (ctl.tgt_sel)
            TGT_POS:  tgt_next = pos_c;
            TGT_SCAN: tgt_next = hit ? sa_reg : count_reg;
            default:  tgt_next = tgt_reg;
        endcase
    end

    // Write port: placed value, or the moved element of the current sweep
    always_comb begin
        we    = 1'b0;
        waddr = sa_reg;
        wdata = rdata;
        wa_next = wa_reg;
        if (ctl.wr_val) begin
            we    = 1'b1;
            waddr = tgt_next;
            wdata = val_reg;
        end else if (sv_reg) begin
            unique case (ctl.run_mode)
                SW_UP, SW_DN: begin
                    we = 1'b1;
                end
                SW_CMP: begin
                    we      = !eq;
                    waddr   = wa_reg;
                    wa_next = eq ? wa_reg : wa_reg + CW'(1);
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
        if (ctl.init_mode != SW_NONE) begin
            wa_next = '0;
        end
    end

    always_comb begin
        ra_next = issue ? ra_step : ra_reg;
        unique case (ctl.init_mode)
            SW_UP:           ra_next = count_reg;
            SW_DN:           ra_next = pos_c + CW'(1);
            SW_SCAN, SW_CMP: ra_next = '0;
            default:         ra_next = issue ? ra_step : ra_reg;
        endcase
    end

    always_comb begin
        unique case (ctl.cnt_op)
            CNT_INC:     count_next = count_reg + CW'(1);
            CNT_DEC:     count_next = count_reg - CW'(1);
            CNT_LOAD_WA: count_next = wa_reg;
            default:     count_next = count_reg;
        endcase
    end

    oss_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr[AW-1:0]),
        .wdata (wdata),
        .raddr (rd_addr[AW-1:0]),
        .rdata (rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            sv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            sv_reg    <= sv_next;
            if (ctl.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctl.cap) begin
            op_reg  <= s_tdata[CMD_W-1:0];
            pos_reg <= s_tdata[CMD_W+POS_W-1:CMD_W];
            val_reg <= DW'(s_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W]);
        end
        tgt_reg <= tgt_next;
        ra_reg  <= ra_next;
        wa_reg  <= wa_next;
        sa_reg  <= sa_next;
        if (ctl.res_load) begin
            res_status_reg <= (ctl.res_kind == RK_REJECT);
            res_rd_reg     <= (ctl.res_kind == RK_READ) ? VAL_W'(rdata) : '0;
            res_rem_reg    <= (ctl.res_kind == RK_REMOVE) ? CNT_W'(count_reg - wa_reg) : '0;
            unique case (ctl.res_kind)
                RK_INDEX: res_idx_reg <= IDX_W'(tgt_next);
                RK_READ:  res_idx_reg <= IDX_W'(tgt_reg);
                default:  res_idx_reg <= '1;
            endcase
        end
        if (ctl.out_load) begin
            out_data_reg <= {(count_reg == '0), CNT_W'(count_reg), res_rem_reg,
                             res_rd_reg, res_idx_reg, res_status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat.op       = op_reg;
    assign stat.ins_ok   = (pos_x <= cnt_x);
    assign stat.acc_ok   = (pos_x < cnt_x);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.hit      = hit;
    assign stat.done     = done;
    assign stat.out_free = !out_valid_reg || m_tready;
endmodule

>>> sv/ordered_sequence_store.sv
// Top level of the ordered sequence store: sorted insert list with command stream.
//
// Usage:
//   Each input beat on s_* carries one command (insert at a position, sorted insert,
//   erase at a position, remove all equal, get, set, find) and yields exactly one
//   result beat on m_* with status, index (-1 when none), read data, removed count,
//   element count after the command and an empty flag.
//   The list lives compacted at the front of one DEPTH-word RAM with one write and
//   one registered read port; every element move or compare is one RAM read.
//   Steps: set and rejected commands go from decode straight to the reply step; get
//   reads its element first; insert shifts the tail up from the end to the position,
//   erase shifts it down, sorted insert and find scan from the front (sorted insert
//   then shifts), remove all compacts the whole list in one pass.
//   One command is in work at a time; s_tready is high only while the sequencer
//   is idle. The result register lets the next command be taken while a result
//   still waits; when the receiver stalls, hold the finished result and stall the
//   following one in its reply step.
//   Reset (aresetn low, synchronous) empties the list at once; no clearing pass
//   is run, stale RAM words are never read.
module ordered_sequence_store #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // command beat
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // s_tdata, low bit up: command[2:0], position[9:3], value[41:10], zero[47:42]
    input  logic [oss_pkg::IN_W-1:0]  s_tdata,
    // result beat
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // m_tdata, low bit up: status[0], index[8:1], read_value[40:9],
    // removed_count[47:41], element_count[54:48], is_empty[55]
    output logic [oss_pkg::OUT_W-1:0] m_tdata
);
    import oss_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    // Sequencer: decode, run the sweep, queue the reply
    oss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Element RAM, counters and result register
    oss_dpath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    // One command at a time: drop ready right after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken while one is in work");

    // Never grow a full list
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        !((ctl.cnt_op == CNT_INC) && stat.full))
        else $error("element count advanced past depth");

    // Load the result register only when it is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> stat.out_free)
        else $error("pending result overwritten");
`endif
endmodule

>>> tb/sv/oss_reply_checker.sv
// Reply checker for the ordered sequence store: shadow list, prediction and comparison.
`timescale 1ns / 1ps

module oss_reply_checker #(
    parameter int DEPTH = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [oss_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [oss_pkg::OUT_W-1:0] m_tdata,
    output int                        mismatches,
    output int                        in_flight,
    output int                        list_size,
    output int                        replies_checked,
    output int                        full_refusals
);
    import oss_pkg::*;

    localparam logic [IDX_W-1:0] NO_INDEX = '1;

    // Packed so that status lands in bit 0, matching the result beat layout
    typedef struct packed {
        logic             is_empty;
        logic [CNT_W-1:0] element_count;
        logic [CNT_W-1:0] removed_count;
        logic [VAL_W-1:0] read_value;
        logic [IDX_W-1:0] index;
        logic             status;
    } reply_t;

    logic [VAL_W-1:0] shadow_list [DEPTH];
    int               list_len;
    int               refusal_total;
    int               fail_total;
    int               checked_total;
    reply_t           pending_replies [$];

    function automatic void open_slot(input int at, input logic [VAL_W-1:0] val);
        for (int k = list_len; k > at; k--)
            shadow_list[k] = shadow_list[k-1];
        shadow_list[at] = val;
        list_len++;
    endfunction

    function automatic reply_t apply_command(input op_t cmd, input logic [POS_W-1:0] pos,
                                             input logic [VAL_W-1:0] val);
        reply_t r;
        int     i;
        int     j;
        r        = '0;
        r.status = 1'b1;
        r.index  = NO_INDEX;
        case (cmd)
            OP_INSERT_AT: begin
                if (list_len >= DEPTH) begin
                    refusal_total++;
                end else if (int'(pos) <= list_len) begin
                    open_slot(int'(pos), val);
                    r.status = 1'b0;
                    r.index  = {1'b0, pos};
                end
            end
            OP_SORTED_INSERT: begin
                i = 0;
                while (i < list_len && shadow_list[i] < val)
                    i++;
                if (list_len >= DEPTH) begin
                    refusal_total++;
                end else begin
                    open_slot(i, val);
                    r.status = 1'b0;
                    r.index  = IDX_W'(i);
                end
            end
            OP_ERASE_AT: begin
                if (int'(pos) < list_len) begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    list_len--;
                    r.status = 1'b0;
                    r.index  = {1'b0, pos};
                end
            end
            OP_REMOVE_ALL: begin
                j = 0;
                for (i = 0; i < list_len; i++)
                    if (shadow_list[i] != val) begin
                        shadow_list[j] = shadow_list[i];
                        j++;
                    end
                r.removed_count = CNT_W'(list_len - j);
                list_len        = j;
                r.status        = 1'b0;
            end
            OP_GET: begin
                if (int'(pos) < list_len) begin
                    r.status     = 1'b0;
                    r.index      = {1'b0, pos};
                    r.read_value = shadow_list[pos];
                end
            end
            OP_SET: begin
                if (int'(pos) < list_len) begin
                    shadow_list[pos] = val;
                    r.status         = 1'b0;
                    r.index          = {1'b0, pos};
                end
            end
            OP_FIND: begin
                i = 0;
                while (i < list_len && shadow_list[i] != val)
                    i++;
                if (i < list_len) begin
                    r.status = 1'b0;
                    r.index  = IDX_W'(i);
                end
            end
            default: ;
        endcase
        r.element_count = CNT_W'(list_len);
        r.is_empty      = (list_len == 0);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            list_len      = 0;
            refusal_total = 0;
            fail_total    = 0;
            checked_total = 0;
            pending_replies.delete();
        end else begin
            // Check the reply first: it always belongs to an older command
            if (m_tvalid && m_tready) begin
                got = reply_t'(m_tdata);
                if (pending_replies.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected result beat with nothing pending: %h", m_tdata);
                end else begin
                    want = pending_replies.pop_front();
                    checked_total++;
                    if (got.status !== want.status || got.index !== want.index ||
                        got.read_value !== want.read_value ||
                        got.removed_count !== want.removed_count ||
                        got.element_count !== want.element_count ||
                        got.is_empty !== want.is_empty) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("result %0d mismatch: expected st=%0b idx=%0d rd=%h rem=%0d cnt=%0d empty=%0b",
                                     checked_total, want.status, $signed(want.index),
                                     want.read_value, want.removed_count,
                                     want.element_count, want.is_empty);
                            $display("    got st=%0b idx=%0d rd=%h rem=%0d cnt=%0d empty=%0b",
                                     got.status, $signed(got.index), got.read_value,
                                     got.removed_count, got.element_count, got.is_empty);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(apply_command(op_t'(s_tdata[CMD_W-1:0]),
                                                        s_tdata[CMD_W +: POS_W],
                                                        s_tdata[CMD_W+POS_W +: VAL_W]));
        end
        mismatches      <= fail_total;
        in_flight       <= pending_replies.size();
        list_size       <= list_len;
        replies_checked <= checked_total;
        full_refusals   <= refusal_total;
    end

endmodule

>>> tb/sv/tb_top.sv
// Stimulus, clock, reset and verdict for the ordered sequence store testbench.
`timescale 1ns / 1ps

module tb_top;
    import oss_pkg::*;

    localparam int  DEPTH        = 64;
    localparam int  RANDOM_BEATS = 1750;
    localparam int  PHASE_BEATS  = 250;
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  DRAIN_CYCLES = 150;     // longest command sweeps the whole list
    localparam int  IDLE_PCT     = 38;
    // Code 7 is not a command; the block must refuse it
    localparam op_t OP_UNUSED    = 3'd7;

    // Phase mix: fill the list, churn it, or drain it
    localparam int  MIX_FILL  = 0;
    localparam int  MIX_CHURN = 1;
    localparam int  MIX_DRAIN = 2;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // s_tdata, low bit up: command[2:0], position[9:3], value[41:10], zero[47:42]
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // m_tdata, low bit up: status[0], index[8:1], read_value[40:9],
    // removed_count[47:41], element_count[54:48], is_empty[55]
    logic [OUT_W-1:0] m_tdata;

    int   fail_count;
    int   in_flight;
    int   list_size;
    int   replies_checked;
    int   full_refusals;
    int   cycle_count = 0;
    int   ops_sent [8];
    logic quiet = 1'b0;     // high while neither side may idle

    // Values that repeat often, so that find and remove hit
    logic [VAL_W-1:0] value_pool [12] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7,
                                          32'h8};

    ordered_sequence_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VAL_W)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    oss_reply_checker #(
        .DEPTH (DEPTH)
    ) u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (fail_count),
        .in_flight       (in_flight),
        .list_size       (list_size),
        .replies_checked (replies_checked),
        .full_refusals   (full_refusals)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Stall the result side at random, except in the quiet stretch
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: end the run if the block hangs or loses a result
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, in_flight);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one command beat and hold it until the block takes it. A random gap
    // with tvalid low goes in front; without a gap, tvalid stays high from the
    // previous beat and only the data changes.
    task automatic send_beat(input op_t cmd, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - CMD_W - POS_W - VAL_W){1'b0}}, val, pos, cmd};
        ops_sent[cmd]++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Draw one command shaped by the phase mix. The list size seen here lags by a
    // beat or so; that only blurs the aim, the checker tracks the true state.
    task automatic send_random(input int mix);
        int               weight [8];
        int               roll;
        int               sz;
        op_t              cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        case (mix)
            MIX_FILL: weight = '{35, 35, 5, 3, 8, 5, 8, 1};
            MIX_DRAIN: weight = '{5, 5, 40, 20, 10, 5, 13, 2};
            default: weight = '{15, 15, 15, 8, 15, 12, 18, 2};
        endcase
        roll = $urandom_range(0, 99);
        cmd  = OP_UNUSED;
        for (int k = 0; k < 8; k++) begin
            if (roll < weight[k]) begin
                cmd = op_t'(k);
                break;
            end
            roll -= weight[k];
        end

        sz   = list_size;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end else if (cmd == OP_INSERT_AT) begin
            pos = (roll < 30) ? POS_W'(sz) : POS_W'($urandom_range(0, sz));
        end else if (sz > 0) begin
            pos = (roll < 30) ? POS_W'(sz - 1) : POS_W'($urandom_range(0, sz - 1));
        end else begin
            pos = '0;
        end

        if ($urandom_range(0, 99) < 45)
            val = value_pool[$urandom_range(0, 11)];
        else
            val = $urandom;
        send_beat(cmd, pos, val);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list refusals, edge values, sorted placement, misses
        send_beat(OP_GET,           7'd0,   32'h0);
        send_beat(OP_ERASE_AT,      7'd0,   32'h0);
        send_beat(OP_SET,           7'd0,   32'h1234_5678);
        send_beat(OP_FIND,          7'd0,   32'h0);
        send_beat(OP_REMOVE_ALL,    7'd0,   32'h0);
        send_beat(OP_INSERT_AT,     7'd1,   32'h1);          // past the end of an empty list
        send_beat(OP_INSERT_AT,     7'd0,   32'hFFFF_FFFF);
        send_beat(OP_SORTED_INSERT, 7'd0,   32'h0);
        send_beat(OP_SORTED_INSERT, 7'd0,   32'hFFFF_FFFF);  // ties go before the equal one
        send_beat(OP_SORTED_INSERT, 7'd0,   32'h8000_0000);
        send_beat(OP_SET,           7'd3,   32'h5);
        send_beat(OP_ERASE_AT,      7'd2,   32'h0);
        send_beat(OP_ERASE_AT,      7'd2,   32'h0);
        send_beat(OP_SORTED_INSERT, 7'd0,   32'h9000_0000);  // larger than all, lands at end
        send_beat(OP_INSERT_AT,     7'd3,   32'h7FFF_FFFF);  // exactly at the end
        send_beat(OP_INSERT_AT,     7'd5,   32'h2);
        send_beat(OP_GET,           7'd1,   32'h0);
        send_beat(OP_GET,           7'd127, 32'h0);
        send_beat(OP_FIND,          7'd0,   32'h8000_0000);
        send_beat(OP_FIND,          7'd0,   32'h1234_5678);
        send_beat(OP_REMOVE_ALL,    7'd0,   32'h8000_0000);
        send_beat(OP_SET,           7'd0,   32'h5555_5555);
        send_beat(OP_GET,           7'd0,   32'h0);
        send_beat(OP_UNUSED,        7'd127, 32'hFFFF_FFFF);
        send_beat(OP_ERASE_AT,      7'd127, 32'h0);

        // Random: alternate fill, churn and drain so the list runs full and empty
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            case (n / PHASE_BEATS)
                0, 3, 5: begin
                    if (n % PHASE_BEATS == 0) quiet <= 1'b0;
                    send_random(MIX_FILL);
                end
                2, 6: begin
                    if (n % PHASE_BEATS == 0) quiet <= 1'b0;
                    send_random(MIX_DRAIN);
                end
                4: begin
                    // Hold both sides busy for the whole phase
                    if (n % PHASE_BEATS == 0) quiet <= 1'b1;
                    send_random(MIX_CHURN);
                end
                default: send_random(MIX_CHURN);
            endcase
        end
        s_tvalid <= 1'b0;
        quiet    <= 1'b0;

        // Drain: wait for every result, then watch for strays
        do @(posedge aclk); while (in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("commands: insert %0d, sorted %0d, erase %0d, remove %0d, get %0d, set %0d, find %0d, unused %0d",
                 ops_sent[OP_INSERT_AT], ops_sent[OP_SORTED_INSERT], ops_sent[OP_ERASE_AT],
                 ops_sent[OP_REMOVE_ALL], ops_sent[OP_GET], ops_sent[OP_SET],
                 ops_sent[OP_FIND], ops_sent[OP_UNUSED]);
        $display("results compared: %0d, inserts refused on a full list: %0d, mismatches: %0d",
                 replies_checked, full_refusals, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
